>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL; clocked on i_clk, quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bec_pkg.sv
// Shared constants, types and helpers of the cross-shaped binary erosion block.
`timescale 1ns / 1ps

package bec_pkg;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register file
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

    // Input word carries one pixel in bit 0
    localparam int IN_TDATA_W = 8;

    // Line buffer reload sequencer
    typedef enum logic [1:0] {
        ST_LOAD0,
        ST_LOAD1,
        ST_RUN
    } t_fill_state;

    // Last valid index of a dimension: zero counts as one, large values saturate
    function automatic int dim_last(input logic [CFG_W-1:0] v, input int maxv);
        int res;
        if (v == '0) begin
            res = 0;
        end else if (int'(v) > maxv) begin
            res = maxv - 1;
        end else begin
            res = int'(v) - 1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/binary_erosion_cross.sv
// Top level: 4-connected binary erosion over a raster pixel stream, two-row line buffer.
//
//  channel   dir  word                                   handshake
//  s_axis    in   pixel_in                               tvalid / tready
//  m_axis    out  pixel_out, out_row, out_col; tlast     tvalid / tready
//  cfg       in   image_width (0), image_height (1)      i_cfg_wr_en, no wait
//
//  One pixel per cycle while s_axis_tready is high; each accepted pixel below row 0
//  queues the result of the pixel above it. On the last row each pixel gives two
//  words (one in a one-row frame), so that row is paced by the single-word output
//  port and its three-entry result queue. After reset and after every configuration
//  write the line buffer prefetch is reloaded through ST_LOAD0 and ST_LOAD1, s_axis_tready low.
//  Reset (synchronous, i_rst_n low) clears counters, the queue and the sequencer.
`timescale 1ns / 1ps

module binary_erosion_cross #(
    parameter int MAX_WIDTH  = bec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bec_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W       = $clog2(MAX_WIDTH),
    localparam int ROW_W       = $clog2(MAX_HEIGHT),
    localparam int OUT_TDATA_W = ((1 + ROW_W + COL_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bec_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] pixel_in, rest zero
    // stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          m_axis_tdata,   // pixel_out, out_row, out_col, zeros
    output logic                            m_axis_tlast,   // frame_last
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [bec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bec_pkg::CFG_W-1:0]       i_cfg_wdata
);

    import bec_pkg::*;

    localparam int QUEUE_DEPTH = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             pixel;
        logic             last;
    } t_result;

    // Configuration: last column and last row index, already clamped
    logic [COL_W-1:0] r_col_last;
    logic [ROW_W-1:0] r_row_last;

    // Position of the next input pixel
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // Line buffer word: [1] row r-2, [0] row r-1
    logic [1:0]       r_m0;          // word at the current column
    logic [1:0]       ram_rd_data;   // word at the next column
    logic             r_cprev;       // row r-1 pixel one column to the left
    logic             ram_rd_en;
    logic [COL_W-1:0] ram_rd_addr;

    t_fill_state      r_state, n_state;
    logic             st_run, st_load1;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_result          r_q [QUEUE_DEPTH];
    t_result          n_q [QUEUE_DEPTH];

    logic             in_acc, out_pop;
    logic             pix, up, center, right;
    logic             last_col, last_row;
    logic [COL_W-1:0] pos1, pos2;
    logic             has0, has1;
    t_result          res0, res1;
    logic             head_border;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(dim_last(IMAGE_WIDTH_RST, MAX_WIDTH));
            r_row_last <= ROW_W'(dim_last(IMAGE_HEIGHT_RST, MAX_HEIGHT));
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_col_last <= COL_W'(dim_last(i_cfg_wdata, MAX_WIDTH));
                REG_IMAGE_HEIGHT: r_row_last <= ROW_W'(dim_last(i_cfg_wdata, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // Reload sequencer: next state
    always_comb begin
        case (r_state)
            ST_LOAD0: n_state = ST_LOAD1;
            ST_LOAD1: n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_LOAD0;
        endcase
        if (i_cfg_wr_en) begin
            n_state = ST_LOAD0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD0;
        end else begin
            r_state <= n_state;
        end
    end

    // Reload sequencer: outputs
    always_comb begin
        st_run   = 1'b0;
        st_load1 = 1'b0;
        case (r_state)
            ST_LOAD0: ;
            ST_LOAD1: st_load1 = 1'b1;
            ST_RUN:   st_run   = 1'b1;
            default:  ;
        endcase
    end

    // Handshakes
    assign s_axis_tready = st_run && (r_cnt <= CNT_W'(1));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    // Column one and two steps ahead, wrapping at the row end
    always_comb begin
        pos1 = (r_col >= r_col_last) ? '0 : r_col + COL_W'(1);
        pos2 = (pos1 >= r_col_last) ? '0 : pos1 + COL_W'(1);
    end

    // Prefetch read: current column, then next column, then two ahead per pixel
    always_comb begin
        case (r_state)
            ST_LOAD0: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_col;
            end
            ST_LOAD1: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos1;
            end
            default: begin
                ram_rd_en   = in_acc;
                ram_rd_addr = pos2;
            end
        endcase
    end

    bec_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_col),
        .i_wr_data ({center, pix}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Cross window and the results of one pixel
    always_comb begin
        pix      = s_axis_tdata[0];
        up       = r_m0[1];
        center   = r_m0[0];
        right    = ram_rd_data[0];
        last_col = (r_col >= r_col_last);
        last_row = (r_row >= r_row_last);

        has0      = (r_row != '0);
        res0.col  = r_col;
        res0.row  = r_row - ROW_W'(1);
        res0.last = 1'b0;
        res0.pixel = (r_row != ROW_W'(1)) && (r_col != '0) && !last_col &&
                     up && center && right && r_cprev && pix;

        // Last row is all border
        has1       = last_row;
        res1.col   = r_col;
        res1.row   = r_row;
        res1.last  = last_col;
        res1.pixel = 1'b0;
    end

    // Position counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_cprev <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_cprev <= last_col ? 1'b0 : center;
            end
        end
    end

    // Window shift: the prefetched word becomes the current column
    always_ff @(posedge i_clk) begin
        if (st_load1 || in_acc) begin
            r_m0 <= ram_rd_data;
        end
    end

    // Result queue: shift out at the head, append up to two words
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (out_pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - CNT_W'(1);
        end
        if (in_acc) begin
            if (has0) begin
                n_q[n_cnt[$clog2(QUEUE_DEPTH)-1:0]] = res0;
                n_cnt = n_cnt + CNT_W'(1);
            end
            if (has1) begin
                n_q[n_cnt[$clog2(QUEUE_DEPTH)-1:0]] = res1;
                n_cnt = n_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign m_axis_tdata = OUT_TDATA_W'({r_q[0].col, r_q[0].row, r_q[0].pixel});
    assign m_axis_tlast = r_q[0].last;

    // Head word sits on the top or left frame border
    assign head_border = (r_q[0].col == '0) || (r_q[0].row == '0);

    // Checks
    `include "assert_macros.svh"

    `AST_NOW(a_last_clear, m_axis_tvalid && m_axis_tlast, !r_q[0].pixel, "frame end word set")
    `AST_NOW(a_border_clear, m_axis_tvalid && r_q[0].pixel, !head_border, "border pixel set")
    `AST_NEXT(a_row_result, in_acc && (r_row != '0), m_axis_tvalid, "row result missing")
    `AST_NEXT(a_two_words, in_acc && has0 && has1, r_cnt >= CNT_W'(2), "last row word lost")

endmodule

>>> rtl/core/bec_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bec_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> dv/binary_erosion_cross_tb.sv
// Self-checking bench for the cross erosion block: random frames, gapped stream, scoreboard.
`timescale 1ns / 1ps

module binary_erosion_cross_tb;
    import bec_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS = 380;

    // one eroded output word as the block should emit it
    typedef struct packed {
        logic       pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_eroded_px;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_TDATA_W-1:0] s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [23:0]           m_data;
    logic                  m_last;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // stimulus and scoreboard
    bit         pixel_queue[$];
    t_eroded_px expected_px[$];
    int         fail_count = 0;
    int         items_accepted = 0;
    bit         calm = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         hold_cnt = 0;
    bit         hold_done = 1'b0;

    // mirror of the block state
    logic [CFG_W-1:0] width_reg = IMAGE_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = IMAGE_HEIGHT_RST;
    bit               line_up  [0:LINE_DEPTH-1];
    bit               line_mid [0:LINE_DEPTH-1];
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;
    bit               mid_prev = 1'b0;

    binary_erosion_cross DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // [0] pixel_in, rest zero
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),    // [0] pixel_out, [10:1] out_row, [20:11] out_col
        .m_axis_tlast  (m_last),    // frame_last
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // zero counts as one, oversize saturates
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(v);
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 75)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // erode one incoming pixel and queue the words it releases
    task automatic erode_pixel(input bit pix);
        int unsigned w, h, c, r, ci;
        bit          at_last_col, at_last_row, up, mid, right, left, res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        c = col_pos;
        r = row_pos;
        ci = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
        at_last_col = (c >= w - 1);
        at_last_row = (r >= h - 1);
        up = line_up[ci];
        mid = line_mid[ci];
        right = (ci + 1 < LINE_DEPTH) ? line_mid[ci + 1] : 1'b0;
        left = mid_prev;
        mid_prev = mid;
        // pending row r-1 word
        if (r >= 1) begin
            res = 1'b0;
            if (r - 1 != 0 && c != 0 && !at_last_col)
                res = up & mid & right & left & pix;
            expected_px.push_back('{pix: res, row: 10'(r - 1), col: 10'(c), last: 1'b0});
        end
        // last-row border word
        if (at_last_row)
            expected_px.push_back('{pix: 1'b0, row: 10'(r), col: 10'(c), last: at_last_col});
        line_up[ci] = mid;
        line_mid[ci] = pix;
        if (at_last_col) begin
            col_pos = 0;
            mid_prev = 1'b0;
            row_pos = at_last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // driver: feeds pixels from the queue, gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                erode_pixel(s_data[0]);
                items_accepted <= items_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid <= 1'b0;
                    s_data <= {{(IN_TDATA_W-1){1'b0}}, 1'($urandom_range(0, 1))};
                    send_gap <= send_gap - 1;
                end else if (pixel_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= {{(IN_TDATA_W-1){1'b0}}, pixel_queue.pop_front()};
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, while the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && items_accepted >= 700 && pixel_queue.size() != 0) begin
            hold_cnt <= 400;
            hold_done <= 1'b1;
        end
    end

    // monitor: compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        t_eroded_px want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected word: pix %0b row %0d col %0d last %0b",
                                 m_data[0], m_data[10:1], m_data[20:11], m_last);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_px.pop_front();
                    if (m_data[0] !== want.pix || m_data[10:1] !== want.row ||
                        m_data[20:11] !== want.col || m_last !== want.last) begin
                        if (fail_count < 10) begin
                            $display("mismatch: exp pix %0b row %0d col %0d last %0b",
                                     want.pix, want.row, want.col, want.last);
                            $display("          got pix %0b row %0d col %0d last %0b",
                                     m_data[0], m_data[10:1], m_data[20:11], m_last);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (hold_cnt != 0) begin
                m_ready <= 1'b0;
            end else if (recv_stall != 0) begin
                m_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cfg_wdata <= 11'($urandom_range(0, 2047));
    endtask

    // queue one frame at the current size, density in percent of set pixels
    task automatic queue_frame(input int density, output int count);
        int unsigned w, h;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        count = w * h;
        for (int i = 0; i < count; i++)
            pixel_queue.push_back($urandom_range(0, 99) < density);
    endtask

    // wait until every pixel is in and every word is out, then let the pipe settle
    task automatic drain_and_settle();
        while (pixel_queue.size() != 0 || s_valid || expected_px.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // sequence: reset, directed frames, random frames, size extremes
    initial begin
        int random_items;
        int n, frames, dens, pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all set 4x4: only the inner 2x2 survives
        write_reg(REG_IMAGE_WIDTH, 11'd4);
        write_reg(REG_IMAGE_HEIGHT, 11'd4);
        queue_frame(100, n);
        drain_and_settle();
        // zero sizes count as one: single pixel frame
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        queue_frame(100, n);
        drain_and_settle();
        // single row, mixed pixels
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd1);
        pixel_queue.push_back(1'b1);
        pixel_queue.push_back(1'b0);
        pixel_queue.push_back(1'b1);
        drain_and_settle();

        // random frames, one to three per setting so the counters wrap
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 2);
            if (pick != 2)
                write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 15) == 0) ? 11'd0 :
                          ($urandom_range(0, 9) < 7) ? 11'($urandom_range(1, 12)) :
                                                       11'($urandom_range(13, 40)));
            if (pick != 1)
                write_reg(REG_IMAGE_HEIGHT, ($urandom_range(0, 15) == 0) ? 11'd0 :
                          11'($urandom_range(1, 10)));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (random_items < RANDOM_ITEMS) begin
                    dens = ($urandom_range(0, 3) == 0) ? 50 : 88;
                    queue_frame(dens, n);
                    random_items += n;
                end
            end
            drain_and_settle();
        end

        // oversize width saturates to a full line, one row
        calm = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 11'd2047);
        write_reg(REG_IMAGE_HEIGHT, 11'd1);
        queue_frame(90, n);
        drain_and_settle();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_px.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
